FILE: sv/aced_pkg.sv
// Shared types for the C escape decoder: channel payloads, config bundle,
// register indexes and the burst record that runs from the front end to the
// output side. No dependencies.
package aced_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       stopped;
    logic       stream_end;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic       echo_mode;
    logic       parser_mode;
    logic       drop_unknown_backslash;
    logic       stop_on_c;
    logic [7:0] ctl_escape_byte;
    logic [7:0] ctl_null_byte;
  } cfg_t;

  // config register indexes
  typedef enum logic [2:0] {
    REG_ECHO_MODE   = 3'd0,
    REG_PARSER_MODE = 3'd1,
    REG_DROP_BS     = 3'd2,
    REG_STOP_ON_C   = 3'd3,
    REG_CTL_ESC     = 3'd4,
    REG_CTL_NULL    = 3'd5
  } reg_idx_t;

  // all results of one input byte; a marker burst always has cnt 1
  typedef struct packed {
    logic [2:0][7:0] data;
    logic [1:0]      cnt;
    logic            is_mark;
    logic            stopped;
    logic            eos;
  } burst_t;

endpackage

FILE: sv/aced_front.sv
// Front end of the escape decoder: escape state machine, one input byte
// per cycle while accept is high, builds the result burst of each byte.
// Depends on aced_pkg.
module aced_front (
  input  logic              clk,
  input  logic              rst_n,
  input  aced_pkg::cfg_t    cfg,
  input  aced_pkg::in_item_t item,
  input  logic              accept,
  output aced_pkg::burst_t  burst,
  output logic              push
);

  localparam logic [7:0] BS_CHAR  = 8'h5C;
  localparam logic [7:0] ESC_CHAR = 8'h1B;
  localparam logic [7:0] LBRACE   = 8'h7B;
  localparam logic [7:0] RBRACE   = 8'h7D;
  localparam logic [7:0] CTRL_BS  = 8'h1C;  // control form of backslash

  typedef enum logic [2:0] {
    PH_IDLE, PH_ESC, PH_OCT, PH_XSTART, PH_HEX, PH_BRACE, PH_CTL, PH_CTLBS
  } phase_t;

  // up to four bytes before the overflow trim, plus first quote position
  typedef struct packed {
    logic [3:0][7:0] data;
    logic [2:0]      cnt;
    logic            mk_v;
    logic [1:0]      mk_pos;
  } obuf_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] acc_r, acc_nxt;
  logic [1:0] dl_r, dl_nxt;
  logic       disc_r, disc_nxt;

  function automatic obuf_t put_b(obuf_t s, logic [7:0] v);
    obuf_t r;
    r = s;
    if (r.cnt < 3'd4) begin
      r.data[r.cnt[1:0]] = v;
      r.cnt = r.cnt + 3'd1;
    end
    return r;
  endfunction

  function automatic obuf_t put_q(obuf_t s, logic [7:0] v, aced_pkg::cfg_t c);
    obuf_t r;
    r = s;
    if (c.parser_mode && (v == c.ctl_escape_byte || v == c.ctl_null_byte)) begin
      if (!r.mk_v) begin
        r.mk_v   = 1'b1;
        r.mk_pos = r.cnt[1:0];
      end
      r = put_b(r, c.ctl_escape_byte);
    end
    r = put_b(r, v);
    return r;
  endfunction

  function automatic logic is_hex(logic [7:0] v);
    return (v inside {["0":"9"], ["a":"f"], ["A":"F"]});
  endfunction

  function automatic logic [3:0] hex_val(logic [7:0] v);
    logic [7:0] t;
    t = 8'd0;
    if (v inside {["0":"9"]})      t = v - "0";
    else if (v inside {["a":"f"]}) t = v - "a" + 8'd10;
    else                           t = v - "A" + 8'd10;
    return t[3:0];
  endfunction

  function automatic logic [7:0] ctrl_of(logic [7:0] v);
    return (v == "?") ? 8'h7F : {3'b000, v[4:0]};
  endfunction

  // close a pending escape with no more digits
  function automatic obuf_t flush(obuf_t s, phase_t ph, logic [7:0] acc,
                                  aced_pkg::cfg_t c);
    obuf_t r;
    r = s;
    case (ph)
      PH_ESC: r = put_b(r, BS_CHAR);
      PH_OCT, PH_HEX, PH_BRACE: r = put_q(r, acc, c);
      PH_XSTART: begin
        r = put_b(r, BS_CHAR);
        r = put_q(r, "x", c);
      end
      PH_CTL: begin
        if (!c.drop_unknown_backslash) r = put_b(r, BS_CHAR);
        r = put_q(r, "c", c);
      end
      PH_CTLBS: r = put_q(r, CTRL_BS, c);
      default: r = s;
    endcase
    return r;
  endfunction

  always_comb begin
    logic [7:0] b, ch;
    logic       eos, marker, stopm, taken, emit, bs_first, is_mk;
    obuf_t      s;

    b         = item.in_byte;
    eos       = item.end_of_string;
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    dl_nxt    = dl_r;
    disc_nxt  = disc_r;
    s         = '0;
    marker    = 1'b0;
    stopm     = 1'b0;
    taken     = 1'b0;
    emit      = 1'b1;
    bs_first  = 1'b0;
    ch        = b;

    if (disc_r) begin
      if (eos) begin
        marker    = 1'b1;
        stopm     = 1'b1;
        disc_nxt  = 1'b0;
        phase_nxt = PH_IDLE;
        acc_nxt   = 8'd0;
        dl_nxt    = 2'd0;
      end
    end else if (phase_r == PH_IDLE) begin
      if (b == BS_CHAR && !eos) phase_nxt = PH_ESC;
      else                      s = put_b(s, b);
    end else if (phase_r == PH_ESC) begin
      phase_nxt = PH_IDLE;
      acc_nxt   = 8'd0;
      dl_nxt    = 2'd0;
      case (b)
        "a": ch = 8'h07;
        "b": ch = 8'h08;
        "e", "E": ch = ESC_CHAR;
        "f": ch = 8'h0C;
        "n": ch = 8'h0A;
        "r": ch = 8'h0D;
        "t": ch = 8'h09;
        "v": ch = 8'h0B;
        "1", "2", "3", "4", "5", "6", "7": begin
          if (cfg.echo_mode) begin
            bs_first = 1'b1;
          end else begin
            acc_nxt   = {5'b00000, b[2:0]};
            dl_nxt    = 2'd2;
            phase_nxt = PH_OCT;
            emit      = 1'b0;
          end
        end
        "0": begin
          dl_nxt    = cfg.echo_mode ? 2'd3 : 2'd2;
          phase_nxt = PH_OCT;
          emit      = 1'b0;
        end
        "x": begin
          phase_nxt = PH_XSTART;
          emit      = 1'b0;
        end
        BS_CHAR: ch = BS_CHAR;
        "'", "\"", "?": bs_first = cfg.echo_mode;
        "c": begin
          if (cfg.stop_on_c) begin
            emit     = 1'b0;
            marker   = 1'b1;
            stopm    = 1'b1;
            disc_nxt = !eos;
          end else if (!cfg.echo_mode) begin
            phase_nxt = PH_CTL;
            emit      = 1'b0;
          end else begin
            bs_first = !cfg.drop_unknown_backslash;
          end
        end
        default: bs_first = !cfg.drop_unknown_backslash;
      endcase
      if (bs_first) s = put_b(s, BS_CHAR);
      if (emit)     s = put_q(s, ch, cfg);
    end else begin
      // offer the byte to the pending escape
      case (phase_r)
        PH_OCT: begin
          if ((b inside {["0":"7"]}) && dl_r != 2'd0) begin
            taken   = 1'b1;
            acc_nxt = {acc_r[4:0], b[2:0]};
            dl_nxt  = dl_r - 2'd1;
          end
        end
        PH_XSTART: begin
          if (cfg.parser_mode && b == LBRACE) begin
            taken     = 1'b1;
            phase_nxt = PH_BRACE;
          end else if (is_hex(b)) begin
            taken     = 1'b1;
            acc_nxt   = {4'h0, hex_val(b)};
            dl_nxt    = 2'd1;
            phase_nxt = PH_HEX;
          end
        end
        PH_HEX: begin
          if (is_hex(b) && dl_r != 2'd0) begin
            taken   = 1'b1;
            acc_nxt = {acc_r[3:0], hex_val(b)};
            dl_nxt  = dl_r - 2'd1;
          end
        end
        PH_BRACE: begin
          if (is_hex(b)) begin
            taken   = 1'b1;
            acc_nxt = {acc_r[3:0], hex_val(b)};
          end else if (b == RBRACE) begin
            taken = 1'b1;
            s     = flush(s, PH_BRACE, acc_r, cfg);
            phase_nxt = PH_IDLE;
            acc_nxt   = 8'd0;
            dl_nxt    = 2'd0;
          end
        end
        PH_CTL: begin
          if (b != 8'h00) begin
            taken = 1'b1;
            if (cfg.parser_mode && b == BS_CHAR) begin
              phase_nxt = PH_CTLBS;
            end else begin
              phase_nxt = PH_IDLE;
              acc_nxt   = 8'd0;
              dl_nxt    = 2'd0;
              s         = put_q(s, ctrl_of(b), cfg);
            end
          end
        end
        PH_CTLBS: begin
          if (b == BS_CHAR) begin
            taken     = 1'b1;
            phase_nxt = PH_IDLE;
            acc_nxt   = 8'd0;
            dl_nxt    = 2'd0;
            s         = put_q(s, CTRL_BS, cfg);
          end
        end
        default: taken = 1'b0;
      endcase
      // digit count ran out: the number is complete
      if (taken && (phase_r == PH_OCT || phase_r == PH_HEX) && dl_nxt == 2'd0) begin
        s         = flush(s, phase_r, acc_nxt, cfg);
        phase_nxt = PH_IDLE;
        acc_nxt   = 8'd0;
      end
      if (!taken) begin
        s         = flush(s, phase_r, acc_r, cfg);
        phase_nxt = PH_IDLE;
        acc_nxt   = 8'd0;
        dl_nxt    = 2'd0;
        if (b == BS_CHAR && !eos) phase_nxt = PH_ESC;
        else                      s = put_b(s, b);
      end
    end

    // end of string closes whatever is pending
    if (eos && !stopm) begin
      if (phase_nxt != PH_IDLE) s = flush(s, phase_nxt, acc_nxt, cfg);
      phase_nxt = PH_IDLE;
      acc_nxt   = 8'd0;
      dl_nxt    = 2'd0;
    end

    // four bytes do not fit: drop the first quote marker, then clip
    if (s.cnt > 3'd3 && s.mk_v) begin
      for (int i = 0; i < 3; i++) begin
        if (i >= int'(s.mk_pos)) s.data[i] = s.data[i+1];
      end
    end
    if (s.cnt > 3'd3) s.cnt = 3'd3;

    is_mk         = marker || (eos && s.cnt == 3'd0);
    burst.is_mark = is_mk;
    burst.stopped = stopm;
    burst.eos     = eos;
    burst.cnt     = is_mk ? 2'd1 : s.cnt[1:0];
    burst.data    = is_mk ? '0 : s.data[2:0];
    push          = accept && (is_mk || s.cnt != 3'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      acc_r   <= 8'd0;
      dl_r    <= 2'd0;
      disc_r  <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      dl_r    <= dl_nxt;
      disc_r  <= disc_nxt;
    end
  end

endmodule

FILE: sv/aced_fifo.sv
// Burst queue between decoder front end and output side.
// Depends on aced_pkg.
module aced_fifo #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  aced_pkg::burst_t wr_data,
  input  logic             pop,
  output aced_pkg::burst_t head,
  output logic             empty,
  output logic             full
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  aced_pkg::burst_t mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign empty = (count_r == CW'(0));
  assign full  = (count_r == CW'(DEPTH));
  assign head  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
      if (pop)  rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
      if (push && !pop)      count_r <= count_r + CW'(1);
      else if (pop && !push) count_r <= count_r - CW'(1);
    end
  end

endmodule

FILE: sv/aced_back.sv
// Output side of the decoder: splits each queued burst into result beats
// behind an output register. Depends on aced_pkg.
module aced_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  aced_pkg::burst_t     head,
  input  logic                 head_valid,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output aced_pkg::out_item_t  out_data
);

  logic [1:0]          idx_r;
  logic                out_valid_r;
  aced_pkg::out_item_t out_r;
  aced_pkg::out_item_t beat;
  logic                load, final_beat;

  assign load       = head_valid && (!out_valid_r || out_ready);
  assign final_beat = (idx_r == head.cnt - 2'd1);
  assign pop        = load && final_beat;

  always_comb begin
    beat.out_byte   = head.is_mark ? 8'd0 : head.data[idx_r];
    beat.byte_valid = !head.is_mark;
    beat.stopped    = head.stopped;
    beat.stream_end = head.eos && final_beat;
    beat.last       = final_beat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      idx_r       <= final_beat ? 2'd0 : idx_r + 2'd1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_r <= beat;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: sv/ansi_c_escape_decoder_unit.sv
// Top level of the C string escape decoder: config registers, front end,
// burst queue and output side. Depends on aced_pkg, aced_front, aced_fifo,
// aced_back.
//
// Usage:
//  - in_*: one raw string byte per beat, end_of_string marks the last byte.
//    The front end takes a byte every cycle while the burst queue has room.
//  - out_*: one decoded result per beat. A byte causes zero to three
//    results; last flags the final one of each byte, stream_end the final
//    one of a string. Markers (byte_valid 0) carry end or stop status.
//  - cfg_*: register writes by index, always ready; write only while idle.
//    Indexes beyond the register list are ignored.
//  - Path: each byte's burst is written into the burst queue, then its
//    first result is loaded into the output register that drives out_valid.
//  - Throughput: one byte in and one result out per cycle while the queue
//    has room and out_ready is high; a byte with two or three results
//    holds the output side; the QUEUE_DEPTH-entry burst queue absorbs them.
//  - Receiver stall: results hold in the output register, the queue fills,
//    then in_ready drops; nothing is lost.
//  - Reset (rst_n low, synchronous): escape state idle, queue empty, output
//    empty, registers back to defaults (CTL escape 0x01, CTL null 0x7F).
module ansi_c_escape_decoder_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  aced_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output aced_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [7:0]          cfg_data
);

  aced_pkg::cfg_t   cfg_r;
  aced_pkg::burst_t burst, head;
  logic             push, pop, q_empty, q_full, accept;

  assign cfg_ready = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.echo_mode              <= 1'b0;
      cfg_r.parser_mode            <= 1'b0;
      cfg_r.drop_unknown_backslash <= 1'b0;
      cfg_r.stop_on_c              <= 1'b0;
      cfg_r.ctl_escape_byte        <= 8'h01;
      cfg_r.ctl_null_byte          <= 8'h7F;
    end else if (cfg_valid) begin
      case (aced_pkg::reg_idx_t'(cfg_index))
        aced_pkg::REG_ECHO_MODE:   cfg_r.echo_mode              <= cfg_data[0];
        aced_pkg::REG_PARSER_MODE: cfg_r.parser_mode            <= cfg_data[0];
        aced_pkg::REG_DROP_BS:     cfg_r.drop_unknown_backslash <= cfg_data[0];
        aced_pkg::REG_STOP_ON_C:   cfg_r.stop_on_c              <= cfg_data[0];
        aced_pkg::REG_CTL_ESC:     cfg_r.ctl_escape_byte        <= cfg_data;
        aced_pkg::REG_CTL_NULL:    cfg_r.ctl_null_byte          <= cfg_data;
        default:                   cfg_r <= cfg_r;
      endcase
    end
  end

  // a byte is taken whenever its burst has a free queue slot
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  aced_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .item   (in_data),
    .accept (accept),
    .burst  (burst),
    .push   (push)
  );

  aced_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (burst),
    .pop     (pop),
    .head    (head),
    .empty   (q_empty),
    .full    (q_full)
  );

  aced_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (!q_empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

`ifndef SYNTHESIS
  a_stop_is_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.stopped |-> !out_data.byte_valid && out_data.last)
    else $error("stop result carries a byte");

  a_marker_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.byte_valid |-> out_data.out_byte == 8'd0 && out_data.last)
    else $error("marker result malformed");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.stream_end |-> out_data.last)
    else $error("stream end not on last result");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("burst pushed into full queue");
`endif

endmodule
